// ===== rtl/sepm_pkg.sv =====
// Shared types, constants and helpers for the stream exit pattern matcher.
package sepm_pkg;

  // Largest pattern the hold buffer can carry.
  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Register file geometry follows the fixed field widths.
  localparam int unsigned PAT_W      = 128;
  localparam int unsigned PAT_IDX_W  = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned TMO_RESET  = 10;

  // Low-margin test: 100 * left < 30 * budget.
  localparam int unsigned PERCENT_FULL = 100;
  localparam int unsigned MARGIN_MIN   = 30;
  localparam int unsigned SCALED_W     = 23;

  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_MATCHED = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE          = 3'd0,
    OP_IGNORE        = 3'd1,
    OP_TICK          = 3'd2,
    OP_TIMEOUT_EMPTY = 3'd3,
    OP_TIMEOUT_START = 3'd4,
    OP_PASS          = 3'd5,
    OP_HOLD          = 3'd6,
    OP_DRAIN         = 3'd7
  } op_e;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [CNT_W-1:0] len;
    logic [TMO_W-1:0] timeout;
    logic             len_wr;
    logic             tmo_wr;
    logic [TMO_W-1:0] tmo_val;
  } cfg_t;

  typedef struct packed {
    op_e     op;
    status_e drain_status;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic kind;
    logic len_zero;
    logic hc_zero;
    logic hc_one;
    logic hc_ge_len;
    logic continues;
    logic completes;
    logic ir_gt1;
    logic prefix_ok;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                          input logic [PAT_IDX_W-1:0] idx);
    pat_byte = pat[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== rtl/sepm_regs.sv =====
// Configuration register file behind the APB-style port.
module sepm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sepm_pkg::ADDR_W-1:0]   paddr,
  input  logic [sepm_pkg::DATA_W-1:0]   pwdata,
  output logic [sepm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output sepm_pkg::cfg_t                cfg_o
);

  logic [63:0]                  pat_lo_q, pat_hi_q;
  logic [sepm_pkg::LEN_W-1:0]   len_q;
  logic [sepm_pkg::TMO_W-1:0]   tmo_q;
  logic                         wr;
  sepm_pkg::reg_e               idx;
  logic                         len_clamp;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = sepm_pkg::reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      tmo_q    <= sepm_pkg::TMO_W'(sepm_pkg::TMO_RESET);
    end else if (wr) begin
      case (idx)
        sepm_pkg::REG_PAT_LO:  pat_lo_q <= pwdata[63:0];
        sepm_pkg::REG_PAT_HI:  pat_hi_q <= pwdata[63:0];
        sepm_pkg::REG_PAT_LEN: len_q    <= pwdata[sepm_pkg::LEN_W-1:0];
        sepm_pkg::REG_TIMEOUT: tmo_q    <= pwdata[sepm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sepm_pkg::REG_PAT_LO:  prdata = pat_lo_q;
      sepm_pkg::REG_PAT_HI:  prdata = pat_hi_q;
      sepm_pkg::REG_PAT_LEN: prdata = sepm_pkg::DATA_W'(len_q);
      sepm_pkg::REG_TIMEOUT: prdata = sepm_pkg::DATA_W'(tmo_q);
      default:               prdata = '0;
    endcase
  end

  // Lengths above the buffer depth behave as the full depth.
  assign len_clamp = {1'b0, len_q} > 6'(sepm_pkg::PATTERN_MAX);

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.len     = len_clamp ? sepm_pkg::CNT_W'(sepm_pkg::PATTERN_MAX)
                                   : sepm_pkg::CNT_W'(len_q);
  assign cfg_o.timeout = tmo_q;
  assign cfg_o.len_wr  = wr && (idx == sepm_pkg::REG_PAT_LEN);
  assign cfg_o.tmo_wr  = wr && (idx == sepm_pkg::REG_TIMEOUT);
  assign cfg_o.tmo_val = pwdata[sepm_pkg::TMO_W-1:0];

endmodule

// ===== rtl/sepm_ctrl.sv =====
// Controller: decodes each request and sequences the release of held bytes.
module sepm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sepm_pkg::stat_t stat_i,
  output sepm_pkg::cmd_t  cmd_o
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic              state_q, state_d;
  sepm_pkg::status_e mode_q, mode_d;
  logic              accept;

  assign accept     = (state_q == S_IDLE) && in_valid_i && stat_i.out_free;
  assign in_stall_o = !((state_q == S_IDLE) && stat_i.out_free);

  always_comb begin
    state_d            = state_q;
    mode_d             = mode_q;
    cmd_o.op           = sepm_pkg::OP_NONE;
    cmd_o.drain_status = mode_q;
    cmd_o.last         = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (stat_i.finished) begin
            cmd_o.op = sepm_pkg::OP_IGNORE;
          end else if (stat_i.kind) begin
            if (stat_i.ir_gt1) begin
              cmd_o.op = sepm_pkg::OP_TICK;
            end else if (stat_i.hc_zero) begin
              cmd_o.op = sepm_pkg::OP_TIMEOUT_EMPTY;
            end else begin
              cmd_o.op = sepm_pkg::OP_TIMEOUT_START;
              mode_d   = sepm_pkg::ST_TIMEOUT;
              state_d  = S_DRAIN;
            end
          end else if (stat_i.len_zero) begin
            cmd_o.op = sepm_pkg::OP_PASS;
          end else if (stat_i.continues) begin
            cmd_o.op = sepm_pkg::OP_HOLD;
            if (stat_i.completes) begin
              mode_d  = sepm_pkg::ST_MATCHED;
              state_d = S_DRAIN;
            end
          end else if (stat_i.hc_zero || stat_i.hc_ge_len) begin
            cmd_o.op = sepm_pkg::OP_PASS;
          end else begin
            // Mismatch: hold the new byte too, then release until a prefix remains.
            cmd_o.op = sepm_pkg::OP_HOLD;
            mode_d   = sepm_pkg::ST_DATA;
            state_d  = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (stat_i.out_free) begin
          cmd_o.op   = sepm_pkg::OP_DRAIN;
          cmd_o.last = stat_i.hc_one ||
                       ((mode_q == sepm_pkg::ST_DATA) && stat_i.prefix_ok);
          if (cmd_o.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= sepm_pkg::ST_DATA;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

// ===== rtl/sepm_dp.sv =====
// Datapath: hold buffer, counters, match compare and the result register.
module sepm_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_kind_i,
  input  logic [7:0]                  in_rx_byte_i,
  input  sepm_pkg::cfg_t              cfg_i,
  input  sepm_pkg::cmd_t              cmd_i,
  output sepm_pkg::stat_t             stat_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        out_has_byte_o,
  output logic [7:0]                  out_released_byte_o,
  output logic [1:0]                  out_status_o,
  output logic [sepm_pkg::TMO_W-1:0]  out_intervals_left_o,
  output logic                        out_margin_low_o,
  output logic                        out_last_o
);

  logic [7:0]                    buf_q [sepm_pkg::PATTERN_MAX];
  logic [sepm_pkg::CNT_W-1:0]    hc_q, hc_d, rest;
  logic [sepm_pkg::TMO_W-1:0]    ir_q, ir_d;
  logic                          fin_q, fin_d;
  logic [7:0]                    pat_now;
  logic [sepm_pkg::PATTERN_MAX-1:0] ok;
  logic [sepm_pkg::SCALED_W-1:0] left_scaled, budget_scaled;
  logic                          low;
  logic                          out_free;

  logic                          emit;
  logic                          e_has, e_low, e_last;
  logic [7:0]                    e_byte;
  sepm_pkg::status_e             e_status;
  logic [sepm_pkg::TMO_W-1:0]    e_left;

  logic                          vld_q, has_q, low_q, last_q;
  logic [7:0]                    byte_q;
  logic [1:0]                    status_q;
  logic [sepm_pkg::TMO_W-1:0]    left_q;

  assign out_free = !vld_q || !out_stall_i;
  assign pat_now  = sepm_pkg::pat_byte(cfg_i.pattern, sepm_pkg::PAT_IDX_W'(hc_q));
  assign rest     = hc_q - sepm_pkg::CNT_W'(1);

  // After releasing the oldest byte, do the remaining ones start the pattern?
  always_comb begin
    ok = '1;
    for (int j = 0; j < int'(sepm_pkg::PATTERN_MAX) - 1; j++) begin
      ok[j] = (sepm_pkg::CNT_W'(j) >= rest) ||
              (buf_q[j+1] == sepm_pkg::pat_byte(cfg_i.pattern, sepm_pkg::PAT_IDX_W'(j)));
    end
  end

  assign left_scaled   = sepm_pkg::SCALED_W'(ir_q) *
                         sepm_pkg::SCALED_W'(sepm_pkg::PERCENT_FULL);
  assign budget_scaled = sepm_pkg::SCALED_W'(cfg_i.timeout) *
                         sepm_pkg::SCALED_W'(sepm_pkg::MARGIN_MIN);
  assign low           = left_scaled < budget_scaled;

  assign stat_o.finished  = fin_q;
  assign stat_o.kind      = in_kind_i;
  assign stat_o.len_zero  = (cfg_i.len == '0);
  assign stat_o.hc_zero   = (hc_q == '0);
  assign stat_o.hc_one    = (hc_q == sepm_pkg::CNT_W'(1));
  assign stat_o.hc_ge_len = (hc_q >= cfg_i.len);
  assign stat_o.continues = (hc_q < cfg_i.len) && (in_rx_byte_i == pat_now);
  assign stat_o.completes = ((hc_q + sepm_pkg::CNT_W'(1)) == cfg_i.len);
  assign stat_o.ir_gt1    = (ir_q > sepm_pkg::TMO_W'(1));
  assign stat_o.prefix_ok = &ok;
  assign stat_o.out_free  = out_free;

  always_comb begin
    hc_d     = hc_q;
    ir_d     = ir_q;
    fin_d    = fin_q;
    emit     = 1'b0;
    e_has    = 1'b0;
    e_byte   = '0;
    e_status = sepm_pkg::ST_DATA;
    e_left   = '0;
    e_low    = 1'b0;
    e_last   = 1'b1;
    case (cmd_i.op)
      sepm_pkg::OP_IGNORE: begin
        emit     = 1'b1;
        e_status = sepm_pkg::ST_IGNORED;
      end
      sepm_pkg::OP_TICK: ir_d = ir_q - sepm_pkg::TMO_W'(1);
      sepm_pkg::OP_TIMEOUT_EMPTY: begin
        ir_d     = '0;
        fin_d    = 1'b1;
        emit     = 1'b1;
        e_status = sepm_pkg::ST_TIMEOUT;
      end
      sepm_pkg::OP_TIMEOUT_START: ir_d = '0;
      sepm_pkg::OP_PASS: begin
        hc_d   = '0;
        emit   = 1'b1;
        e_has  = 1'b1;
        e_byte = in_rx_byte_i;
      end
      sepm_pkg::OP_HOLD: hc_d = hc_q + sepm_pkg::CNT_W'(1);
      sepm_pkg::OP_DRAIN: begin
        emit     = 1'b1;
        e_has    = 1'b1;
        e_byte   = buf_q[0];
        e_status = cmd_i.drain_status;
        e_last   = cmd_i.last;
        hc_d     = rest;
        if (cmd_i.drain_status == sepm_pkg::ST_MATCHED) begin
          e_left = ir_q;
          e_low  = low;
        end
        if (cmd_i.last && (cmd_i.drain_status != sepm_pkg::ST_DATA)) begin
          fin_d = 1'b1;
        end
      end
      default: ;
    endcase
    if (cfg_i.len_wr) begin
      hc_d = '0;
    end
    if (cfg_i.tmo_wr) begin
      ir_d = cfg_i.tmo_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= '0;
      ir_q  <= sepm_pkg::TMO_W'(sepm_pkg::TMO_RESET);
      fin_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      hc_q  <= hc_d;
      ir_q  <= ir_d;
      fin_q <= fin_d;
      if (emit) begin
        vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      has_q    <= e_has;
      byte_q   <= e_byte;
      status_q <= e_status;
      left_q   <= e_left;
      low_q    <= e_low;
      last_q   <= e_last;
    end
  end

  // Hold buffer is a shift line: new bytes land at the fill point, releases
  // always take entry zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sepm_pkg::OP_HOLD) begin
      buf_q[hc_q[sepm_pkg::IDX_W-1:0]] <= in_rx_byte_i;
    end else if (cmd_i.op == sepm_pkg::OP_DRAIN) begin
      for (int j = 0; j < int'(sepm_pkg::PATTERN_MAX) - 1; j++) begin
        buf_q[j] <= buf_q[j+1];
      end
    end
  end

  assign out_valid_o          = vld_q;
  assign out_has_byte_o       = has_q;
  assign out_released_byte_o  = byte_q;
  assign out_status_o         = status_q;
  assign out_intervals_left_o = left_q;
  assign out_margin_low_o     = low_q;
  assign out_last_o           = last_q;

endmodule

// ===== rtl/stream_exit_pattern_matcher_top.sv =====
// Top level of the stream exit pattern matcher: registers, controller and datapath.
// A request that holds a byte of a continuing partial match, or counts an idle tick, gives no result.
// A pass-through, ignored or empty-timeout request shows its one result the cycle after it is taken.
// A request that releases N held bytes (N up to 16) drains them: one byte leaves per cycle from the
// hold buffer shift line unless the output stalls; the input is stalled until the last one is out.
// Reset clears all control state, sets pattern length 0, pattern 0 and a timeout budget of 10.
module stream_exit_pattern_matcher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input request channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        in_kind_i,
  input  logic [7:0]                  in_rx_byte_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_has_byte_o,
  output logic [7:0]                  out_released_byte_o,
  output logic [1:0]                  out_status_o,
  output logic [sepm_pkg::TMO_W-1:0]  out_intervals_left_o,
  output logic                        out_margin_low_o,
  output logic                        out_last_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sepm_pkg::ADDR_W-1:0] paddr,
  input  logic [sepm_pkg::DATA_W-1:0] pwdata,
  output logic [sepm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  sepm_pkg::cfg_t  cfg;
  sepm_pkg::cmd_t  cmd;
  sepm_pkg::stat_t stat;

  // The register file hands the clamped pattern length and the write strobes
  // that discard held bytes or reload the idle budget.
  sepm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller takes a request only when idle and the result register can
  // accept a new entry, then steps the datapath through any release sequence.
  sepm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the partial match, the idle budget, the finished flag
  // and the one-entry result register that drives the output ports.
  sepm_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_kind_i            (in_kind_i),
    .in_rx_byte_i         (in_rx_byte_i),
    .cfg_i                (cfg),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .out_has_byte_o       (out_has_byte_o),
    .out_released_byte_o  (out_released_byte_o),
    .out_status_o         (out_status_o),
    .out_intervals_left_o (out_intervals_left_o),
    .out_margin_low_o     (out_margin_low_o),
    .out_last_o           (out_last_o)
  );

endmodule

// ===== rtl/sepm_checker.sv =====
// Port-level checks for the stream exit pattern matcher, bound to the top level.
module sepm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        out_has_byte_o,
  input logic [1:0]                  out_status_o,
  input logic [sepm_pkg::TMO_W-1:0]  out_intervals_left_o,
  input logic                        out_margin_low_o,
  input logic                        out_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_ignored_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == sepm_pkg::ST_IGNORED) |-> out_last_o && !out_has_byte_o)
    else $error("ignored result must be a lone empty result");

  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_status_o == sepm_pkg::ST_DATA) ||
                    (out_status_o == sepm_pkg::ST_MATCHED)) |-> out_has_byte_o)
    else $error("data or matched result without a byte");

  a_match_only_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != sepm_pkg::ST_MATCHED)
      |-> (out_intervals_left_o == '0) && !out_margin_low_o)
    else $error("match fields set on a non-matched result");

endmodule

bind stream_exit_pattern_matcher_top sepm_checker u_sepm_checker (.*);

// ===== verif/sepm_release_checker.sv =====
// Result checker for the stream exit pattern matcher: predicts released bytes and compares them.
module sepm_release_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          in_kind_i,
  input  logic [7:0]                    in_rx_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          out_has_byte_i,
  input  logic [7:0]                    out_released_byte_i,
  input  logic [1:0]                    out_status_i,
  input  logic [sepm_pkg::TMO_W-1:0]    out_intervals_left_i,
  input  logic                          out_margin_low_i,
  input  logic                          out_last_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [sepm_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [sepm_pkg::DATA_W-1:0]   pwdata_i,
  output int                            mismatches_o,
  output int                            pending_o
);

  typedef struct packed {
    logic                       has_byte;
    logic [7:0]                 released;
    sepm_pkg::status_e          status;
    logic [sepm_pkg::TMO_W-1:0] left;
    logic                       margin_low;
    logic                       last;
  } release_t;

  logic [63:0]                pat_lo;
  logic [63:0]                pat_hi;
  logic [4:0]                 pat_len_reg;
  logic [sepm_pkg::TMO_W-1:0] budget;
  logic [sepm_pkg::TMO_W-1:0] ivl_left;
  logic [7:0]                 held [sepm_pkg::PATTERN_MAX];
  int unsigned                held_cnt;
  bit                         done;
  release_t                   expected_releases [$];

  function automatic logic [7:0] pattern_at(input int unsigned i);
    return (i < 8) ? pat_lo[(i % 8) * 8 +: 8] : pat_hi[(i % 8) * 8 +: 8];
  endfunction

  task automatic emit(input logic has, input logic [7:0] b, input sepm_pkg::status_e st,
                      input logic [sepm_pkg::TMO_W-1:0] left, input logic low);
    release_t r;
    r = '{has_byte: has, released: has ? b : 8'h00, status: st, left: left,
          margin_low: low, last: 1'b0};
    expected_releases.push_back(r);
  endtask

  task automatic apply_write(input sepm_pkg::reg_e r, input logic [sepm_pkg::DATA_W-1:0] d);
    case (r)
      sepm_pkg::REG_PAT_LO:  pat_lo = d;
      sepm_pkg::REG_PAT_HI:  pat_hi = d;
      sepm_pkg::REG_PAT_LEN: begin
        pat_len_reg = d[4:0];
        held_cnt = 0;
      end
      sepm_pkg::REG_TIMEOUT: begin
        budget = d[sepm_pkg::TMO_W-1:0];
        ivl_left = d[sepm_pkg::TMO_W-1:0];
      end
      default: ;
    endcase
  endtask

  // Works out the results of one accepted request and advances the shadow state.
  task automatic predict_release(input logic kind, input logic [7:0] c);
    int unsigned len;
    int unsigned cur;
    int unsigned rest;
    int unsigned n;
    int unsigned m;
    int unsigned before_cnt;
    logic        low;
    bit          same;
    release_t    r;
    len = (pat_len_reg > sepm_pkg::PATTERN_MAX) ? sepm_pkg::PATTERN_MAX : 32'(pat_len_reg);
    before_cnt = expected_releases.size();
    if (done) begin
      emit(1'b0, 8'h00, sepm_pkg::ST_IGNORED, '0, 1'b0);
    end else if (kind) begin
      if (ivl_left > 1) begin
        ivl_left = ivl_left - 1'b1;
      end else begin
        ivl_left = '0;
        for (n = 0; n < held_cnt; n++) emit(1'b1, held[n], sepm_pkg::ST_TIMEOUT, '0, 1'b0);
        if (held_cnt == 0) emit(1'b0, 8'h00, sepm_pkg::ST_TIMEOUT, '0, 1'b0);
        held_cnt = 0;
        done = 1'b1;
      end
    end else if (len == 0) begin
      emit(1'b1, c, sepm_pkg::ST_DATA, '0, 1'b0);
    end else if (held_cnt < len && c == pattern_at(held_cnt)) begin
      held[held_cnt] = c;
      held_cnt++;
      if (held_cnt == len) begin
        low = (64'(ivl_left) * sepm_pkg::PERCENT_FULL < 64'(budget) * sepm_pkg::MARGIN_MIN);
        for (n = 0; n < len; n++) emit(1'b1, held[n], sepm_pkg::ST_MATCHED, ivl_left, low);
        held_cnt = 0;
        done = 1'b1;
      end
    end else if (held_cnt == 0 || held_cnt >= len) begin
      held_cnt = 0;
      emit(1'b1, c, sepm_pkg::ST_DATA, '0, 1'b0);
    end else begin
      // Release oldest bytes until what is left is a pattern prefix again.
      cur = held_cnt + 1;
      held[held_cnt] = c;
      for (n = 1; n <= cur; n++) begin
        rest = cur - n;
        emit(1'b1, held[n-1], sepm_pkg::ST_DATA, '0, 1'b0);
        same = 1'b1;
        for (m = 0; m < rest; m++) if (held[n+m] != pattern_at(m)) same = 1'b0;
        if (same) begin
          for (m = 0; m < rest; m++) held[m] = held[n+m];
          held_cnt = rest;
          break;
        end
      end
    end
    if (expected_releases.size() > before_cnt) begin
      r = expected_releases.pop_back();
      r.last = 1'b1;
      expected_releases.push_back(r);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches_o++;
    if (mismatches_o <= 100)
      $display("[%0t] release check: %s got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic compare_release();
    release_t want;
    if (expected_releases.size() == 0) begin
      flag_mismatch("unexpected result, status", 64'(out_status_i), 64'd0);
      return;
    end
    want = expected_releases.pop_front();
    if (out_has_byte_i != want.has_byte)
      flag_mismatch("has_byte", 64'(out_has_byte_i), 64'(want.has_byte));
    if (out_released_byte_i != want.released)
      flag_mismatch("released_byte", 64'(out_released_byte_i), 64'(want.released));
    if (out_status_i != want.status)
      flag_mismatch("status", 64'(out_status_i), 64'(want.status));
    if (out_intervals_left_i != want.left)
      flag_mismatch("intervals_left", 64'(out_intervals_left_i), 64'(want.left));
    if (out_margin_low_i != want.margin_low)
      flag_mismatch("margin_low", 64'(out_margin_low_i), 64'(want.margin_low));
    if (out_last_i != want.last) flag_mismatch("last", 64'(out_last_i), 64'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo = '0;
      pat_hi = '0;
      pat_len_reg = '0;
      budget = sepm_pkg::TMO_W'(sepm_pkg::TMO_RESET);
      ivl_left = sepm_pkg::TMO_W'(sepm_pkg::TMO_RESET);
      held_cnt = 0;
      done = 1'b0;
      expected_releases.delete();
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i)
        apply_write(sepm_pkg::reg_e'(paddr_i[sepm_pkg::ADDR_W-1:3]), pwdata_i);
      if (in_valid_i && !in_stall_i) predict_release(in_kind_i, in_rx_byte_i);
      if (out_valid_i && !out_stall_i) compare_release();
      pending_o = expected_releases.size();
    end
  end

endmodule

// ===== verif/tb_stream_exit_pattern_matcher_top.sv =====
// Testbench top for the stream exit pattern matcher: stimulus, receiver pacing and verdict.
module tb_stream_exit_pattern_matcher_top;

  // All block inputs start at known values, reset asserted.
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_kind = 1'b0;
  logic [7:0]                    in_rx_byte = 8'h00;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_has_byte;
  logic [7:0]                    out_released_byte;
  logic [1:0]                    out_status;
  logic [sepm_pkg::TMO_W-1:0]    out_intervals_left;
  logic                          out_margin_low;
  logic                          out_last;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [sepm_pkg::ADDR_W-1:0]   paddr = '0;
  logic [sepm_pkg::DATA_W-1:0]   pwdata = '0;
  logic [sepm_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  int                            mismatches;
  int                            pending;

  // Stimulus-side picture of the configuration. The stop byte is the last pattern
  // byte; it appears nowhere earlier in the pattern and is never sent until the
  // closing sequence, so no full match can happen by accident in the random part.
  logic [7:0]                    pat [sepm_pkg::PATTERN_MAX];
  int unsigned                   pat_len = 0;
  logic [7:0]                    stop_byte = 8'h00;
  // Mirrors the idle-interval budget so that random ticks never cause a timeout.
  int unsigned                   ticks_left = sepm_pkg::TMO_RESET;
  int unsigned                   sent = 0;
  // quiet turns off random idling on both sides; holdoff asks the receiver for a
  // long stall so that the block fills up and pushes back on its input.
  bit                            quiet = 1'b0;
  bit                            holdoff = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stream_exit_pattern_matcher_top DUT (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .in_kind_i            (in_kind),
    .in_rx_byte_i         (in_rx_byte),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .out_has_byte_o       (out_has_byte),
    .out_released_byte_o  (out_released_byte),
    .out_status_o         (out_status),
    .out_intervals_left_o (out_intervals_left),
    .out_margin_low_o     (out_margin_low),
    .out_last_o           (out_last),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  sepm_release_checker checker_inst (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .in_kind_i            (in_kind),
    .in_rx_byte_i         (in_rx_byte),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .out_has_byte_i       (out_has_byte),
    .out_released_byte_i  (out_released_byte),
    .out_status_i         (out_status),
    .out_intervals_left_i (out_intervals_left),
    .out_margin_low_i     (out_margin_low),
    .out_last_i           (out_last),
    .psel_i               (psel),
    .penable_i            (penable),
    .pwrite_i             (pwrite),
    .pready_i             (pready),
    .paddr_i              (paddr),
    .pwdata_i             (pwdata),
    .mismatches_o         (mismatches),
    .pending_o            (pending)
  );

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #400000;
    $display("tb_stream_exit_pattern_matcher_top NOT OK");
    $finish;
  end

  // Receiver pacing. Stall changes only at the falling edge. A hold-off request is
  // served by stalling for a fixed number of cycles counted right here.
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff) begin
        out_stall <= 1'b1;
        repeat (90) @(negedge clk);
        holdoff = 1'b0;
      end
      out_stall <= !quiet && ($urandom_range(99) < 28);
    end
  end

  // Offers one request and returns once it has been accepted. Valid stays high
  // through any stall, and the payload is left alone until acceptance.
  task automatic send_request(input logic kind, input logic [7:0] b);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Stops offering requests and waits until every predicted result has arrived.
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Requests that hold bytes or count ticks give no result and may still be in
  // flight when the last result leaves, so give the block time for a full drain
  // before touching any register.
  task automatic settle();
    wait_results_done();
    repeat (20) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle; pready is always high.
  task automatic apb_write(input sepm_pkg::reg_e r, input logic [sepm_pkg::DATA_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_budget(input logic [sepm_pkg::TMO_W-1:0] v);
    apb_write(sepm_pkg::REG_TIMEOUT, sepm_pkg::DATA_W'(v));
    ticks_left = 32'(v);
  endtask

  // Any byte except the stop byte, so an active pattern can never complete.
  function automatic logic [7:0] free_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (pat_len != 0 && b == stop_byte) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    send_request(1'b0, b);
  endtask

  // An idle tick, but only while the budget is far from running out; otherwise a
  // plain byte takes its place.
  task automatic idle_tick();
    if (ticks_left > 2) begin
      send_request(1'b1, 8'($urandom_range(255)));
      ticks_left--;
    end else begin
      send_byte(free_byte());
    end
  endtask

  // Builds a new pattern and writes it. A narrow pattern uses only two byte values
  // before the stop byte, which makes partial re-alignment after a mismatch common.
  // Without the length write, bytes already held stay held and are compared
  // against the new pattern.
  task automatic program_pattern(input logic [4:0] len_field, input bit narrow,
                                 input bit write_len);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  a;
    logic [7:0]  b;
    int unsigned eff;
    bit          clash;
    int          i;
    eff = write_len ? ((len_field > sepm_pkg::PATTERN_MAX) ? sepm_pkg::PATTERN_MAX
                                                           : 32'(len_field))
                    : pat_len;
    a = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    for (i = 0; i < sepm_pkg::PATTERN_MAX; i++)
      pat[i] = narrow ? ($urandom_range(1) ? a : b) : 8'($urandom_range(255));
    if (eff > 0) begin
      do begin
        stop_byte = 8'($urandom_range(255));
        clash = 1'b0;
        for (i = 0; i < eff - 1; i++) if (pat[i] == stop_byte) clash = 1'b1;
      end while (clash);
      pat[eff-1] = stop_byte;
    end
    for (i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = pat[i];
      hi[i*8 +: 8] = pat[i+8];
    end
    apb_write(sepm_pkg::REG_PAT_LO, lo);
    apb_write(sepm_pkg::REG_PAT_HI, hi);
    if (write_len) apb_write(sepm_pkg::REG_PAT_LEN, sepm_pkg::DATA_W'(len_field));
    pat_len = eff;
  endtask

  // A well-formed run: a proper prefix of the pattern, optionally followed by a
  // byte that breaks it (often an earlier pattern byte, to force re-alignment).
  task automatic send_prefix_run(input bit break_it);
    int unsigned k;
    int unsigned i;
    k = $urandom_range(pat_len - 1, 1);
    for (i = 0; i < k; i++) send_byte(pat[i]);
    if (break_it) begin
      if ($urandom_range(1)) send_byte(pat[$urandom_range(pat_len - 2, 0)]);
      else send_byte(free_byte());
    end
  endtask

  task automatic run_items(input int unsigned count);
    int unsigned j;
    int unsigned r;
    for (j = 0; j < count; j++) begin
      r = $urandom_range(99);
      if (r < 20) idle_tick();
      else if (r < 72 && pat_len > 1) send_prefix_run(1'($urandom_range(1)));
      else send_byte(free_byte());
    end
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(2))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] pick_length();
    case ($urandom_range(5))
      0:       return 5'd1;
      1, 2:    return 5'($urandom_range(8, 2));
      3:       return 5'($urandom_range(15, 9));
      4:       return 5'd16;
      default: return 5'($urandom_range(31, 17));
    endcase
  endfunction

  // Pass-through phase: the pattern words take extreme or random values, length 0.
  task automatic pass_through_phase(input bit squeeze);
    apb_write(sepm_pkg::REG_PAT_LO, pick_word());
    apb_write(sepm_pkg::REG_PAT_HI, pick_word());
    apb_write(sepm_pkg::REG_PAT_LEN, '0);
    pat_len = 0;
    if (squeeze) begin
      // Receiver holds off while the sender keeps offering bytes.
      holdoff = 1'b1;
      repeat (30) send_byte(8'($urandom_range(255)));
    end else begin
      run_items($urandom_range(20, 10));
    end
  endtask

  // The one match or timeout of the run. Afterwards every request is ignored, so
  // a few more requests of both kinds check that behavior.
  task automatic finish_stream();
    int unsigned n;
    int unsigned i;
    settle();
    case ($urandom_range(2))
      0: begin
        // Full match with a random share of the budget already used up.
        set_budget(sepm_pkg::TMO_W'($urandom_range(60, 4)));
        program_pattern(5'($urandom_range(16, 1)), 1'($urandom_range(1)), 1'b1);
        n = $urandom_range(ticks_left - 2, 0);
        for (i = 0; i < n; i++) begin
          idle_tick();
          if ($urandom_range(1)) send_byte(free_byte());
        end
        for (i = 0; i < pat_len; i++) send_byte(pat[i]);
      end
      1: begin
        // Timeout with bytes still held back; a budget of one is included.
        set_budget(sepm_pkg::TMO_W'($urandom_range(1) ? 1 : $urandom_range(20, 2)));
        program_pattern(5'($urandom_range(16, 2)), 1'($urandom_range(1)), 1'b1);
        send_byte(free_byte());
        send_prefix_run(1'b0);
        repeat (ticks_left) send_request(1'b1, 8'($urandom_range(255)));
      end
      default: begin
        // Timeout with nothing held.
        set_budget(sepm_pkg::TMO_W'($urandom_range(12, 1)));
        apb_write(sepm_pkg::REG_PAT_LEN, '0);
        pat_len = 0;
        repeat (ticks_left) send_request(1'b1, 8'($urandom_range(255)));
      end
    endcase
    repeat (8) send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0]  breaker;
    int unsigned phase;
    int unsigned count;
    int unsigned i;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Defaults after reset: pass-through and a budget of 10.
    send_byte(8'h00);
    send_byte(8'hFF);
    idle_tick();
    idle_tick();
    settle();
    apb_write(sepm_pkg::REG_PAT_LO, '1);
    apb_write(sepm_pkg::REG_PAT_HI, '0);
    send_byte(8'hA5);

    // Longest pattern: fifteen bytes held, then one byte that releases them all.
    settle();
    set_budget('1);
    program_pattern(5'd16, 1'b0, 1'b1);
    for (i = 0; i < sepm_pkg::PATTERN_MAX - 1; i++) send_byte(pat[i]);
    breaker = free_byte();
    while (breaker == pat[0]) breaker = free_byte();
    send_byte(breaker);

    // Length above the buffer size acts as the full size.
    settle();
    program_pattern(5'd31, 1'b1, 1'b1);
    send_prefix_run(1'b1);
    send_prefix_run(1'b1);
    send_prefix_run(1'b0);

    // New pattern bytes while bytes are still held.
    settle();
    program_pattern('0, 1'b1, 1'b0);
    send_byte(free_byte());
    send_byte(pat[0]);

    // Random part, in phases separated by register changes.
    phase = 0;
    while (sent < 195) begin
      settle();
      quiet = (phase == 3);
      if (phase == 1 || $urandom_range(4) == 0) begin
        pass_through_phase(phase == 1);
      end else begin
        if (pat_len > 1 && $urandom_range(3) == 0)
          program_pattern('0, 1'($urandom_range(1)), 1'b0);
        else
          program_pattern(pick_length(), 1'($urandom_range(1)), 1'b1);
        if (ticks_left < 6 || $urandom_range(3) == 0) begin
          case ($urandom_range(9))
            0:       set_budget(sepm_pkg::TMO_W'(1));
            1, 2:    set_budget('1);
            default: set_budget(sepm_pkg::TMO_W'($urandom_range(300, 6)));
          endcase
        end
        count = $urandom_range(24, 12);
        run_items(count / 2);
        // Now and then the sender waits for the block to empty mid-phase.
        if ($urandom_range(2) == 0) wait_results_done();
        run_items(count - count / 2);
      end
      phase++;
    end
    quiet = 1'b0;

    finish_stream();
    settle();
    if (mismatches == 0) begin
      $display("tb_stream_exit_pattern_matcher_top OK");
    end else begin
      $display("tb_stream_exit_pattern_matcher_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sepm_pkg.sv
rtl/sepm_regs.sv
rtl/sepm_ctrl.sv
rtl/sepm_dp.sv
rtl/stream_exit_pattern_matcher_top.sv
rtl/sepm_checker.sv
verif/sepm_release_checker.sv
verif/tb_stream_exit_pattern_matcher_top.sv
